### hw/rtl/mpa_pkg.sv
// Shared types, constants and helper functions for the max pool / argmax block.
// Used by mpa_scan, mpa_window and max_pool_argmax_unit; depends on nothing.
`timescale 1ns / 1ps

package mpa_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_POOL   = 8;
  localparam int DATA_WIDTH = 16;
  localparam int DIM_LIMIT  = 1024;

  localparam int CFG_W   = 11;                    // configuration register width
  localparam int POOL_W  = 4;                     // pool size register width
  localparam int COORD_W = 10;                    // row, column and channel fields
  localparam int OFF_W   = $clog2(MAX_POOL);      // offset inside a window
  localparam int WX_W    = $clog2(MAX_WIDTH);     // window store address
  localparam int IDX_W   = 3;                     // configuration index width

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_IN_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_IN_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_CHANNELS  = 3'd2;
  localparam logic [IDX_W-1:0] REG_POOL_W    = 3'd3;
  localparam logic [IDX_W-1:0] REG_POOL_H    = 3'd4;

  // Effective (clamped) dimensions
  typedef struct packed {
    logic [CFG_W-1:0]  dim_w;
    logic [CFG_W-1:0]  dim_h;
    logic [CFG_W-1:0]  dim_c;
    logic [POOL_W-1:0] pool_w;
    logic [POOL_W-1:0] pool_h;
  } dims_t;

  // One window update request from the scanner to the window store
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] seg_max;
    logic [COORD_W-1:0]           seg_col;
    logic [COORD_W-1:0]           row;
    logic                         first_row;
    logic                         emit;
    logic [COORD_W-1:0]           out_row;
    logic [WX_W-1:0]              wx;
    logic [COORD_W-1:0]           channel;
    logic                         last;
  } win_req_t;

  // One entry of the window store
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic [COORD_W-1:0]           row;
    logic [COORD_W-1:0]           col;
  } win_entry_t;

  // One pooled result
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] max_value;
    logic [COORD_W-1:0]           max_row;
    logic [COORD_W-1:0]           max_col;
    logic [COORD_W-1:0]           out_row;
    logic [COORD_W-1:0]           out_col;
    logic [COORD_W-1:0]           channel;
    logic                         last;
  } pool_res_t;

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] r;
    if (v == '0) r = CFG_W'(1);
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  function automatic logic [POOL_W-1:0] clamp_pool(input logic [POOL_W-1:0] v);
    logic [POOL_W-1:0] r;
    if (v == '0) r = POOL_W'(1);
    else if (v > POOL_W'(MAX_POOL)) r = POOL_W'(MAX_POOL);
    else r = v;
    return r;
  endfunction

endpackage

### hw/rtl/mpa_scan.sv
// Raster position tracking and row-segment maximum for the max pool block.
// Depends on mpa_pkg; issues window update requests to mpa_window.
`timescale 1ns / 1ps

module mpa_scan (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  mpa_pkg::dims_t                        dims,
  input  logic                                  restart,
  input  logic                                  accept,
  input  logic signed [mpa_pkg::DATA_WIDTH-1:0] sample,
  output logic                                  req_valid,
  output mpa_pkg::win_req_t                     req
);
  import mpa_pkg::*;

  logic [COORD_W-1:0] col_pos_r, col_pos_nxt;
  logic [COORD_W-1:0] row_pos_r, row_pos_nxt;
  logic [COORD_W-1:0] chan_pos_r, chan_pos_nxt;
  logic [OFF_W-1:0]   ciw_r, ciw_nxt;
  logic [OFF_W-1:0]   riw_r, riw_nxt;
  logic [WX_W-1:0]    wx_r, wx_nxt;
  logic [COORD_W-1:0] oy_r, oy_nxt;
  logic [COORD_W-1:0] base_col_r, base_col_nxt;
  logic [COORD_W-1:0] base_row_r, base_row_nxt;
  logic signed [DATA_WIDTH-1:0] seg_max_r, seg_max_nxt;
  logic [COORD_W-1:0] seg_col_r, seg_col_nxt;

  logic [CFG_W-1:0]  col_p1, row_p1, chan_p1;
  logic [POOL_W-1:0] ciw_p1, riw_p1;
  logic [CFG_W-1:0]  col_end, row_end, col_end2, row_end2;
  logic              col_ok, row_ok, in_region, take, op;

  always_comb begin
    col_p1   = {1'b0, col_pos_r} + CFG_W'(1);
    row_p1   = {1'b0, row_pos_r} + CFG_W'(1);
    chan_p1  = {1'b0, chan_pos_r} + CFG_W'(1);
    ciw_p1   = {1'b0, ciw_r} + POOL_W'(1);
    riw_p1   = {1'b0, riw_r} + POOL_W'(1);
    // end of the current window and of the one after it
    col_end  = {1'b0, base_col_r} + CFG_W'(dims.pool_w);
    row_end  = {1'b0, base_row_r} + CFG_W'(dims.pool_h);
    col_end2 = col_end + CFG_W'(dims.pool_w);
    row_end2 = row_end + CFG_W'(dims.pool_h);
    col_ok    = (col_end <= dims.dim_w);
    row_ok    = (row_end <= dims.dim_h);
    in_region = col_ok && row_ok;
    take      = (ciw_r == '0) || (sample > seg_max_r);
    op        = in_region && (ciw_p1 == dims.pool_w);
  end

  always_comb begin
    req.seg_max   = take ? sample : seg_max_r;
    req.seg_col   = take ? col_pos_r : seg_col_r;
    req.row       = row_pos_r;
    req.first_row = (riw_r == '0);
    req.emit      = (riw_p1 == dims.pool_h);
    req.out_row   = oy_r;
    req.wx        = wx_r;
    req.channel   = chan_pos_r;
    req.last      = (chan_p1 == dims.dim_c) && (row_end2 > dims.dim_h) &&
                    (col_end2 > dims.dim_w);
    req_valid     = accept && op;
  end

  always_comb begin
    col_pos_nxt  = col_pos_r;
    row_pos_nxt  = row_pos_r;
    chan_pos_nxt = chan_pos_r;
    ciw_nxt      = ciw_r;
    riw_nxt      = riw_r;
    wx_nxt       = wx_r;
    oy_nxt       = oy_r;
    base_col_nxt = base_col_r;
    base_row_nxt = base_row_r;
    seg_max_nxt  = seg_max_r;
    seg_col_nxt  = seg_col_r;
    if (restart) begin
      col_pos_nxt  = '0;
      row_pos_nxt  = '0;
      chan_pos_nxt = '0;
      ciw_nxt      = '0;
      riw_nxt      = '0;
      wx_nxt       = '0;
      oy_nxt       = '0;
      base_col_nxt = '0;
      base_row_nxt = '0;
    end else if (accept) begin
      if (in_region) begin
        seg_max_nxt = req.seg_max;
        seg_col_nxt = req.seg_col;
      end
      if (col_p1 >= dims.dim_w) begin
        col_pos_nxt  = '0;
        ciw_nxt      = '0;
        wx_nxt       = '0;
        base_col_nxt = '0;
        if (row_p1 >= dims.dim_h) begin
          row_pos_nxt  = '0;
          riw_nxt      = '0;
          oy_nxt       = '0;
          base_row_nxt = '0;
          chan_pos_nxt = (chan_p1 >= dims.dim_c) ? '0 : chan_p1[COORD_W-1:0];
        end else begin
          row_pos_nxt = row_p1[COORD_W-1:0];
          if (riw_p1 >= dims.pool_h) begin
            riw_nxt      = '0;
            oy_nxt       = oy_r + COORD_W'(1);
            base_row_nxt = row_p1[COORD_W-1:0];
          end else begin
            riw_nxt = riw_p1[OFF_W-1:0];
          end
        end
      end else begin
        col_pos_nxt = col_p1[COORD_W-1:0];
        if (ciw_p1 >= dims.pool_w) begin
          ciw_nxt      = '0;
          wx_nxt       = wx_r + WX_W'(1);
          base_col_nxt = col_p1[COORD_W-1:0];
        end else begin
          ciw_nxt = ciw_p1[OFF_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r  <= '0;
      row_pos_r  <= '0;
      chan_pos_r <= '0;
      ciw_r      <= '0;
      riw_r      <= '0;
      wx_r       <= '0;
      oy_r       <= '0;
      base_col_r <= '0;
      base_row_r <= '0;
      seg_max_r  <= '0;
      seg_col_r  <= '0;
    end else begin
      col_pos_r  <= col_pos_nxt;
      row_pos_r  <= row_pos_nxt;
      chan_pos_r <= chan_pos_nxt;
      ciw_r      <= ciw_nxt;
      riw_r      <= riw_nxt;
      wx_r       <= wx_nxt;
      oy_r       <= oy_nxt;
      base_col_r <= base_col_nxt;
      base_row_r <= base_row_nxt;
      seg_max_r  <= seg_max_nxt;
      seg_col_r  <= seg_col_nxt;
    end
  end

endmodule

### hw/rtl/mpa_window.sv
// Window store: per pooled column running maximum, read-modify-write over one
// synchronous memory with write forwarding. Depends on mpa_pkg.
`timescale 1ns / 1ps

module mpa_window (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               req_valid,
  input  mpa_pkg::win_req_t  req,
  output logic               req_ready,
  output logic               res_valid,
  output mpa_pkg::pool_res_t res,
  input  logic               res_ready
);
  import mpa_pkg::*;

  win_entry_t mem [MAX_WIDTH];
  win_entry_t rd_data_r;
  win_entry_t fwd_data_r;
  logic       fwd_v_r;
  win_req_t   s1_r;
  logic       s1_v_r;

  win_entry_t cur, merged;
  logic       take, s1_done, wr_en;

  always_comb begin
    cur  = fwd_v_r ? fwd_data_r : rd_data_r;
    take = s1_r.first_row ||
           ($signed(s1_r.seg_max) > $signed(cur.value)) ||
           (($signed(s1_r.seg_max) == $signed(cur.value)) && (s1_r.seg_col < cur.col));
    merged.value = take ? s1_r.seg_max : cur.value;
    merged.row   = take ? s1_r.row : cur.row;
    merged.col   = take ? s1_r.seg_col : cur.col;

    s1_done   = !s1_r.emit || res_ready;
    wr_en     = s1_v_r && s1_done;
    req_ready = !s1_v_r || s1_done;
    res_valid = s1_v_r && s1_r.emit;

    res.max_value = merged.value;
    res.max_row   = merged.row;
    res.max_col   = merged.col;
    res.out_row   = s1_r.out_row;
    res.out_col   = COORD_W'(s1_r.wx);
    res.channel   = s1_r.channel;
    res.last      = s1_r.last;
  end

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[s1_r.wx] <= merged;
    if (req_valid) rd_data_r <= mem[req.wx];
  end

  // Capture a same-address write that lands on the read edge
  always_ff @(posedge clk) begin
    if (req_valid) begin
      fwd_data_r <= merged;
      s1_r       <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      if (req_valid) begin
        s1_v_r  <= 1'b1;
        fwd_v_r <= wr_en && (s1_r.wx == req.wx);
      end else if (s1_done) begin
        s1_v_r <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/max_pool_argmax_unit.sv
// Top level of the streaming max pool with argmax block.
// Depends on mpa_pkg, mpa_scan and mpa_window.
//
//   channel | direction | ports
//   --------+-----------+---------------------------------------------------
//   in      | sink      | in_valid, in_ready, in_sample
//   out     | source    | out_valid, out_ready, out_max_value .. out_last
//   cfg     | sink      | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// One sample per cycle is taken while in_ready is high. The edge that accepts the
// sample closing a window segment also reads the window store; the window stage
// then merges and writes it back once its result may leave, and a finished result
// lands in the output register at that same edge and raises out_valid.
// The input stalls only while a finished result sits in the output register
// and the next result wants it; a same-entry write on the read edge is forwarded.
// rst_n (synchronous) clears control state and loads the default dimensions;
// the window store is not cleared, the first row of a window always writes it.
`timescale 1ns / 1ps

module max_pool_argmax_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [mpa_pkg::DATA_WIDTH-1:0] in_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [mpa_pkg::DATA_WIDTH-1:0] out_max_value,
  output logic [mpa_pkg::COORD_W-1:0]           out_max_row,
  output logic [mpa_pkg::COORD_W-1:0]           out_max_col,
  output logic [mpa_pkg::COORD_W-1:0]           out_out_row,
  output logic [mpa_pkg::COORD_W-1:0]           out_out_col,
  output logic [mpa_pkg::COORD_W-1:0]           out_channel,
  output logic                                  out_last,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mpa_pkg::IDX_W-1:0]             cfg_index,
  input  logic [mpa_pkg::CFG_W-1:0]             cfg_data
);
  import mpa_pkg::*;

  // Configuration registers, raw as written
  logic [CFG_W-1:0]  in_width_r, in_height_r, channels_r;
  logic [POOL_W-1:0] pool_w_r, pool_h_r;

  dims_t     dims;
  logic      cfg_wr, restart, accept;
  logic      req_valid, req_ready, res_valid, res_ready;
  win_req_t  req;
  pool_res_t res;

  logic      out_valid_r;
  pool_res_t out_r;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  // Any write to a known register restarts the volume
  assign restart   = cfg_wr && (cfg_index <= REG_POOL_H);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_width_r  <= CFG_W'(32);
      in_height_r <= CFG_W'(32);
      channels_r  <= CFG_W'(1);
      pool_w_r    <= POOL_W'(2);
      pool_h_r    <= POOL_W'(2);
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_IN_WIDTH:  in_width_r  <= cfg_data;
        REG_IN_HEIGHT: in_height_r <= cfg_data;
        REG_CHANNELS:  channels_r  <= cfg_data;
        REG_POOL_W:    pool_w_r    <= cfg_data[POOL_W-1:0];
        REG_POOL_H:    pool_h_r    <= cfg_data[POOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp out-of-range settings to what the datapath supports
  always_comb begin
    dims.dim_w  = clamp_dim(in_width_r, CFG_W'(MAX_WIDTH));
    dims.dim_h  = clamp_dim(in_height_r, CFG_W'(DIM_LIMIT));
    dims.dim_c  = clamp_dim(channels_r, CFG_W'(DIM_LIMIT));
    dims.pool_w = clamp_pool(pool_w_r);
    dims.pool_h = clamp_pool(pool_h_r);
  end

  assign in_ready = req_ready;
  assign accept   = in_valid && in_ready;

  mpa_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .dims      (dims),
    .restart   (restart),
    .accept    (accept),
    .sample    (in_sample),
    .req_valid (req_valid),
    .req       (req)
  );

  mpa_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req       (req),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) out_r <= res;
  end

  assign out_valid     = out_valid_r;
  assign out_max_value = out_r.max_value;
  assign out_max_row   = out_r.max_row;
  assign out_max_col   = out_r.max_col;
  assign out_out_row   = out_r.out_row;
  assign out_out_col   = out_r.out_col;
  assign out_channel   = out_r.channel;
  assign out_last      = out_r.last;

`ifndef NO_ASSERTIONS
  // Input may only stall behind a result that the sink is holding off
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid_r && !out_ready))
    else $error("input stalled without a blocked result");

  // The argmax always lies at or beyond the window's own pooled coordinates
  a_argmax_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_max_row >= out_out_row) && (out_max_col >= out_out_col)))
    else $error("argmax position outside its window");

  // A new result only follows a completed window request
  a_res_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(res_valid))
    else $error("result without a window request");
`endif

endmodule
